FILE: rtl/core/bsf_pkg.sv
package bsf_pkg;

	// Screen geometry and file layout
	localparam int SCREEN_WIDTH  = 800;
	localparam int SCREEN_HEIGHT = 480;
	localparam int HEADER_BYTES  = 54;

	localparam int COL_W  = $clog2(SCREEN_WIDTH);
	localparam int ROW_W  = $clog2(SCREEN_HEIGHT);
	localparam int PROD_W = ROW_W + COL_W;
	localparam int ADDR_W = 19;
	localparam int COLOR_W = 24;

	// Header byte positions
	localparam logic [5:0] HDR_WIDTH_LO  = 6'd18;
	localparam logic [5:0] HDR_WIDTH_HI  = 6'd19;
	localparam logic [5:0] HDR_HEIGHT_LO = 6'd22;
	localparam logic [5:0] HDR_HEIGHT_HI = 6'd23;
	localparam logic [5:0] HDR_BPP_LO    = 6'd28;
	localparam logic [5:0] HDR_BPP_HI    = 6'd29;
	localparam logic [7:0] BPP_32        = 8'd32;

	// Position of a byte within its pixel
	localparam logic [1:0] BIP_BLUE  = 2'd0;
	localparam logic [1:0] BIP_GREEN = 2'd1;
	localparam logic [1:0] BIP_RED   = 2'd2;
	localparam logic [1:0] BIP_PAD   = 2'd3;

	// Configuration port
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 10;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 4'd1;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// One pixel write as the front hands it over
	typedef struct packed {
		logic [15:0]        column;
		logic [15:0]        row_offset;
		logic [COLOR_W-1:0] color;
		logic               last;
	} pixel_job_t;

	typedef struct packed {
		logic full;
		logic not_empty;
	} queue_status_t;

endpackage

FILE: rtl/core/bsf_front.sv
module bsf_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  logic [7:0]         file_byte,
	input  logic               image_start,
	output logic               push,
	output bsf_pkg::pixel_job_t job
);
	import bsf_pkg::*;

	logic [5:0]  hdr_idx_q;
	logic [15:0] img_w_q;
	logic [15:0] img_h_q;
	logic        four_q;
	logic [1:0]  bip_q;
	logic [7:0]  blue_q;
	logic [7:0]  green_q;
	logic [15:0] col_q;
	logic [15:0] row_q;
	logic        done_q;

	logic [5:0]  hdr_idx_d;
	logic [15:0] img_w_d;
	logic [15:0] img_h_d;
	logic        four_d;
	logic [1:0]  bip_d;
	logic [7:0]  blue_d;
	logic [7:0]  green_d;
	logic [15:0] col_d;
	logic [15:0] row_d;
	logic        done_d;
	logic [16:0] col_inc;
	logic [16:0] row_inc;
	logic        is_last;

	// Byte classification: header capture, pixel assembly, raster counters
	always_comb begin
		hdr_idx_d = hdr_idx_q;
		img_w_d   = img_w_q;
		img_h_d   = img_h_q;
		four_d    = four_q;
		bip_d     = bip_q;
		blue_d    = blue_q;
		green_d   = green_q;
		col_d     = col_q;
		row_d     = row_q;
		done_d    = done_q;
		push      = 1'b0;
		col_inc   = {1'b0, col_q} + 17'd1;
		row_inc   = {1'b0, row_q} + 17'd1;
		is_last   = 1'b0;

		// a start byte abandons whatever was in progress
		if (image_start) begin
			hdr_idx_d = '0;
			img_w_d   = '0;
			img_h_d   = '0;
			four_d    = 1'b0;
			bip_d     = BIP_BLUE;
			blue_d    = '0;
			green_d   = '0;
			col_d     = '0;
			row_d     = '0;
			done_d    = 1'b0;
			col_inc   = 17'd1;
			row_inc   = 17'd1;
		end

		if (!done_d) begin
			if (hdr_idx_d < 6'(HEADER_BYTES)) begin
				case (hdr_idx_d)
					HDR_WIDTH_LO:  img_w_d[7:0]  = file_byte;
					HDR_WIDTH_HI:  img_w_d[15:8] = file_byte;
					HDR_HEIGHT_LO: img_h_d[7:0]  = file_byte;
					HDR_HEIGHT_HI: img_h_d[15:8] = file_byte;
					HDR_BPP_LO:    four_d = (file_byte == BPP_32);
					HDR_BPP_HI: begin
						if (file_byte != 8'd0)
							four_d = 1'b0;
					end
					default: ;
				endcase
				hdr_idx_d = 6'(hdr_idx_d + 6'd1);
				// empty image: idle once the header is through
				if (hdr_idx_d >= 6'(HEADER_BYTES) && (img_w_d == '0 || img_h_d == '0))
					done_d = 1'b1;
			end else begin
				case (bip_d)
					BIP_BLUE: begin
						blue_d = file_byte;
						bip_d  = BIP_GREEN;
					end
					BIP_GREEN: begin
						green_d = file_byte;
						bip_d   = BIP_RED;
					end
					BIP_PAD: bip_d = BIP_BLUE;
					default: begin
						push    = 1'b1;
						bip_d   = four_d ? BIP_PAD : BIP_BLUE;
						is_last = (col_inc == {1'b0, img_w_d}) && (row_inc == {1'b0, img_h_d});
						if (col_inc >= {1'b0, img_w_d}) begin
							col_d = '0;
							row_d = row_inc[15:0];
						end else begin
							col_d = col_inc[15:0];
						end
						if (is_last)
							done_d = 1'b1;
					end
				endcase
			end
		end

		push = push & take;
	end

	// Job handed to the queue; row counter is below height, so no wrap
	assign job.column     = image_start ? 16'd0 : col_q;
	assign job.row_offset = 16'(img_h_d - 16'd1 - (image_start ? 16'd0 : row_q));
	assign job.color      = {file_byte, green_d, blue_d};
	assign job.last       = is_last;

	// Per-image state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_idx_q <= '0;
			img_w_q   <= '0;
			img_h_q   <= '0;
			four_q    <= 1'b0;
			bip_q     <= BIP_BLUE;
			blue_q    <= '0;
			green_q   <= '0;
			col_q     <= '0;
			row_q     <= '0;
			done_q    <= 1'b1;
		end else if (take) begin
			hdr_idx_q <= hdr_idx_d;
			img_w_q   <= img_w_d;
			img_h_q   <= img_h_d;
			four_q    <= four_d;
			bip_q     <= bip_d;
			blue_q    <= blue_d;
			green_q   <= green_d;
			col_q     <= col_d;
			row_q     <= row_d;
			done_q    <= done_d;
		end
	end

endmodule

FILE: rtl/core/bsf_queue.sv
module bsf_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  bsf_pkg::pixel_job_t    push_data,
	input  logic                   pop,
	output bsf_pkg::pixel_job_t    pop_data,
	output bsf_pkg::queue_status_t status
);
	import bsf_pkg::*;

	pixel_job_t        mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign status.full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign status.not_empty = (count_q != '0);
	assign pop_data         = mem_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(wr_ptr_q + 1'b1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(rd_ptr_q + 1'b1);
			case ({push, pop})
				2'b10:   count_q <= QCNT_W'(count_q + 1'b1);
				2'b01:   count_q <= QCNT_W'(count_q - 1'b1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/core/bsf_back.sv
module bsf_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [9:0]                        origin_x,
	input  logic [8:0]                        origin_y,
	input  bsf_pkg::queue_status_t            q_status,
	input  bsf_pkg::pixel_job_t               q_data,
	output logic                              q_pop,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [bsf_pkg::ADDR_W-1:0]        pixel_address,
	output logic [bsf_pkg::COLOR_W-1:0]       pixel_color,
	output logic                              on_screen,
	output logic                              last_pixel
);
	import bsf_pkg::*;

	logic [16:0]        col_sum;
	logic [16:0]        row_sum;
	logic               vis;
	logic               adv1;
	logic               adv2;

	logic               v_s1;
	logic [COL_W-1:0]   col_s1;
	logic [ROW_W-1:0]   row_s1;
	logic               vis_s1;
	logic [COLOR_W-1:0] color_s1;
	logic               last_s1;
	logic [PROD_W-1:0]  prod;

	logic               v_s2;

	// Stage advance chain from the output back to the queue
	assign adv2  = !v_s2 || !out_stall;
	assign adv1  = !v_s1 || adv2;
	assign q_pop = q_status.not_empty && adv1;

	// Screen position and clipping
	assign col_sum = {1'b0, q_data.column} + 17'(origin_x);
	assign row_sum = {1'b0, q_data.row_offset} + 17'(origin_y);
	assign vis     = (col_sum < 17'(SCREEN_WIDTH)) && (row_sum < 17'(SCREEN_HEIGHT));

	// Word address of a visible pixel
	assign prod = PROD_W'(row_s1) * PROD_W'(SCREEN_WIDTH) + PROD_W'(col_s1);

	always_ff @(posedge clk) begin
		if (q_pop) begin
			col_s1   <= vis ? col_sum[COL_W-1:0] : '0;
			row_s1   <= vis ? row_sum[ROW_W-1:0] : '0;
			vis_s1   <= vis;
			color_s1 <= q_data.color;
			last_s1  <= q_data.last;
		end
		if (v_s1 && adv2) begin
			pixel_address <= vis_s1 ? ADDR_W'(prod) : '0;
			pixel_color   <= color_s1;
			on_screen     <= vis_s1;
			last_pixel    <= last_s1;
		end
	end

	// Stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1)
				v_s1 <= q_status.not_empty;
			if (adv2)
				v_s2 <= v_s1;
		end
	end

	assign out_valid = v_s2;

endmodule

FILE: rtl/core/bmp_stream_to_framebuffer_unit.sv
// Channel  Direction  Handshake               Payload
// in       input      in_valid / in_stall     file_byte, image_start
// out      output     out_valid / out_stall   pixel_address, pixel_color, on_screen, last_pixel
// cfg      input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// The byte decoder takes one byte every cycle while in_stall is low. A pixel, once its red byte is
// taken, passes the pixel queue, the stage-one register and the output register to be offered.
// in_stall rises only when the two-entry pixel queue is full and out_stall holds.
// Reset leaves the block idle until a byte with image_start arrives.
// cfg_ready is always high; origin registers reset to zero.
module bmp_stream_to_framebuffer_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      file_byte,
	input  logic                            image_start,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [18:0]                     pixel_address,
	output logic [23:0]                     pixel_color,
	output logic                            on_screen,
	output logic                            last_pixel,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bsf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bsf_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import bsf_pkg::*;

	logic          take;
	logic          push;
	logic          pop;
	pixel_job_t    job;
	pixel_job_t    q_data;
	queue_status_t q_status;
	logic [9:0]    origin_x_q;
	logic [8:0]    origin_y_q;

	assign in_stall  = q_status.full;
	assign take      = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// Origin registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ORIGIN_X: origin_x_q <= cfg_data[9:0];
				CFG_ORIGIN_Y: origin_y_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	bsf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.file_byte   (file_byte),
		.image_start (image_start),
		.push        (push),
		.job         (job)
	);

	bsf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (job),
		.pop       (pop),
		.pop_data  (q_data),
		.status    (q_status)
	);

	bsf_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.origin_x      (origin_x_q),
		.origin_y      (origin_y_q),
		.q_status      (q_status),
		.q_data        (q_data),
		.q_pop         (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.pixel_address (pixel_address),
		.pixel_color   (pixel_color),
		.on_screen     (on_screen),
		.last_pixel    (last_pixel)
	);

endmodule

FILE: rtl/core/bsf_checker.sv
module bsf_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic [18:0]                     pixel_address,
	input logic [23:0]                     pixel_color,
	input logic                            on_screen,
	input logic                            last_pixel
);
	import bsf_pkg::*;

	// A stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// Clipped pixels carry address zero
	a_clip_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !on_screen |-> pixel_address == '0)
		else $error("off-screen pixel with non-zero address");

	// Visible pixels stay inside the framebuffer
	a_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && on_screen |-> 32'(pixel_address) < 32'(SCREEN_WIDTH * SCREEN_HEIGHT))
		else $error("pixel address beyond framebuffer");

	// A stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(pixel_address) && $stable(pixel_color) &&
			$stable(on_screen) && $stable(last_pixel))
		else $error("stalled result changed");

endmodule

bind bmp_stream_to_framebuffer_unit bsf_checker u_bsf_checker (.*);

FILE: bench/fb_write_checker.sv
`timescale 1ns / 100ps

module fb_write_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic [7:0]                     file_byte,
	input  logic                           image_start,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [18:0]                    pixel_address,
	input  logic [23:0]                    pixel_color,
	input  logic                           on_screen,
	input  logic                           last_pixel,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [bsf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bsf_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             pending_writes,
	output int                             checked_writes,
	output int                             mismatch_count
);
	import bsf_pkg::*;

	typedef struct packed {
		logic [ADDR_W-1:0]  addr;
		logic [COLOR_W-1:0] color;
		logic               visible;
		logic               last;
	} fb_write_t;

	// Shadow copies of the origin registers
	logic [9:0] org_x;
	logic [8:0] org_y;

	// Per-image decoder state
	logic [5:0]  hdr_pos;
	logic [15:0] img_w;
	logic [15:0] img_h;
	logic        wide_pix;
	logic [1:0]  pix_phase;
	logic [7:0]  blue_q;
	logic [7:0]  green_q;
	logic [15:0] col_n;
	logic [15:0] row_n;
	logic        idle;

	fb_write_t expected_writes[$];
	int        faults = 0;

	assign mismatch_count = faults;

	task automatic forget_image();
		hdr_pos   = '0;
		img_w     = '0;
		img_h     = '0;
		wide_pix  = 1'b0;
		pix_phase = BIP_BLUE;
		blue_q    = '0;
		green_q   = '0;
		col_n     = '0;
		row_n     = '0;
	endtask

	task automatic report(input string field, input logic [23:0] want, input logic [23:0] got);
		if (faults < 10)
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
		faults++;
	endtask

	// Advance the decoder by one byte; a red byte yields one framebuffer write
	task automatic decode_byte(input logic [7:0] b, input logic s);
		fb_write_t w;
		int        col;
		int        row;
		if (s) begin
			forget_image();
			idle = 1'b0;
		end
		if (!idle) begin
			if (hdr_pos < HEADER_BYTES) begin
				case (hdr_pos)
					HDR_WIDTH_LO:  img_w[7:0]  = b;
					HDR_WIDTH_HI:  img_w[15:8] = b;
					HDR_HEIGHT_LO: img_h[7:0]  = b;
					HDR_HEIGHT_HI: img_h[15:8] = b;
					HDR_BPP_LO:    wide_pix = (b == BPP_32);
					HDR_BPP_HI:    if (b != 8'd0) wide_pix = 1'b0;
					default: ;
				endcase
				hdr_pos = hdr_pos + 6'd1;
				// an empty image goes quiet once its header is through
				if (hdr_pos >= HEADER_BYTES && (img_w == 16'd0 || img_h == 16'd0))
					idle = 1'b1;
			end else begin
				case (pix_phase)
					BIP_BLUE: begin
						blue_q    = b;
						pix_phase = BIP_GREEN;
					end
					BIP_GREEN: begin
						green_q   = b;
						pix_phase = BIP_RED;
					end
					BIP_PAD: pix_phase = BIP_BLUE;
					default: begin
						// rows are stored bottom-up
						col       = int'(org_x) + int'(col_n);
						row       = int'(org_y) + int'(img_h) - 1 - int'(row_n);
						w.visible = (col < SCREEN_WIDTH) && (row < SCREEN_HEIGHT);
						w.addr    = w.visible ? ADDR_W'(row * SCREEN_WIDTH + col) : '0;
						w.color   = {b, green_q, blue_q};
						w.last    = (int'(col_n) + 1 == int'(img_w)) &&
						            (int'(row_n) + 1 == int'(img_h));
						expected_writes.push_back(w);
						pix_phase = wide_pix ? BIP_PAD : BIP_BLUE;
						col_n     = col_n + 16'd1;
						if (col_n >= img_w) begin
							col_n = '0;
							row_n = row_n + 16'd1;
						end
						if (w.last)
							idle = 1'b1;
					end
				endcase
			end
		end
	endtask

	// Compare results first: a write cannot leave in the cycle its red byte enters
	always @(posedge clk or negedge arst_n) begin
		fb_write_t got;
		fb_write_t want;
		if (!arst_n) begin
			org_x = '0;
			org_y = '0;
			forget_image();
			idle = 1'b1;
			expected_writes.delete();
			pending_writes <= 0;
			checked_writes <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = '{pixel_address, pixel_color, on_screen, last_pixel};
				if (expected_writes.size() == 0) begin
					if (faults < 10)
						$display("%0t: unexpected pixel write, address %0h color %0h",
							$time, pixel_address, pixel_color);
					faults++;
				end else begin
					want = expected_writes.pop_front();
					if (got.addr !== want.addr)
						report("pixel_address", want.addr, got.addr);
					if (got.color !== want.color)
						report("pixel_color", want.color, got.color);
					if (got.visible !== want.visible)
						report("on_screen", want.visible, got.visible);
					if (got.last !== want.last)
						report("last_pixel", want.last, got.last);
					checked_writes <= checked_writes + 1;
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_ORIGIN_X)
					org_x = cfg_data[9:0];
				else if (cfg_index == CFG_ORIGIN_Y)
					org_y = cfg_data[8:0];
			end
			if (in_valid && !in_stall)
				decode_byte(file_byte, image_start);
			pending_writes <= expected_writes.size();
		end
	end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import bsf_pkg::*;

	localparam int         CYCLE_LIMIT  = 200000;
	localparam int         RANDOM_BYTES = 50;
	localparam logic [7:0] BPP_24       = 8'd24;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  in_valid    = 1'b0;
	logic [7:0]            file_byte   = '0;
	logic                  image_start = 1'b0;
	logic                  out_stall   = 1'b0;
	logic                  cfg_valid   = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index   = '0;
	logic [CFG_DATA_W-1:0] cfg_data    = '0;
	logic                  in_stall;
	logic                  out_valid;
	logic [18:0]           pixel_address;
	logic [23:0]           pixel_color;
	logic                  on_screen;
	logic                  last_pixel;
	logic                  cfg_ready;

	int pending_writes;
	int checked_writes;
	int mismatch_count;

	// Stimulus bookkeeping
	logic calm            = 1'b0;
	int   cycles          = 0;
	int   images_sent     = 0;
	int   origin_settings = 0;
	int   image_bytes     = 0;

	bmp_stream_to_framebuffer_unit dut (.*);

	fb_write_checker u_checker (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles", cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	// Random back-pressure on the pixel side
	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(0, 99) < 23);
	end

	// One byte transaction, with random gaps ahead of it
	task automatic push_byte(input logic [7:0] b, input logic s);
		while (!calm && $urandom_range(0, 99) < 23) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		file_byte   <= b;
		image_start <= s;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic send_noise(input int n);
		repeat (n) push_byte(8'($urandom), 1'b0);
	endtask

	// A whole file, or its first cut bytes; fill < 0 gives random pixel bytes
	task automatic send_image(input int w, input int h, input logic [7:0] bpp_lo,
			input logic [7:0] bpp_hi, input int cut, input int fill);
		logic [7:0] hdr [HEADER_BYTES];
		logic [7:0] b;
		int         total;
		foreach (hdr[i]) hdr[i] = 8'($urandom);
		hdr[HDR_WIDTH_LO]  = w[7:0];
		hdr[HDR_WIDTH_HI]  = w[15:8];
		hdr[HDR_HEIGHT_LO] = h[7:0];
		hdr[HDR_HEIGHT_HI] = h[15:8];
		hdr[HDR_BPP_LO]    = bpp_lo;
		hdr[HDR_BPP_HI]    = bpp_hi;
		total = HEADER_BYTES + w * h * ((bpp_lo == BPP_32 && bpp_hi == 8'd0) ? 4 : 3);
		for (int i = 0; i < total; i++) begin
			if (i == cut)
				break;
			if (i < HEADER_BYTES)
				b = hdr[i];
			else if (fill < 0)
				b = 8'($urandom);
			else
				b = fill[7:0];
			push_byte(b, i == 0);
			image_bytes++;
		end
		images_sent++;
	endtask

	// Wait until every pixel is out and the pipeline has settled
	task automatic quiesce();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_writes != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// Origin change while idle, plus a write to an index outside the map
	task automatic set_origin(input logic [9:0] x, input logic [9:0] y);
		quiesce();
		cfg_write(CFG_ORIGIN_X, x);
		cfg_write(CFG_ORIGIN_Y, y);
		cfg_write(CFG_IDX_W'($urandom_range(2, 15)), CFG_DATA_W'($urandom));
		cfg_valid <= 1'b0;
		origin_settings++;
	endtask

	initial begin
		int         r;
		int         w;
		int         h;
		int         start_bytes;
		logic [9:0] x;
		logic [9:0] y;
		logic [7:0] bpp;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: idle bytes, colour extremes, pad bytes, empty images, restarts
		send_noise(3);
		send_image(1, 1, BPP_24, 8'd0, -1, 'hFF);
		send_noise(2);
		send_image(2, 2, BPP_32, 8'd0, -1, 0);
		send_noise(3);
		send_image(0, 3, BPP_24, 8'd0, -1, -1);
		send_noise(4);
		send_image(3, 0, BPP_32, 8'd0, -1, -1);
		send_noise(2);
		// a long stretch with no gaps and no back-pressure
		calm <= 1'b1;
		send_image(2, 2, BPP_32, 8'h01, -1, -1);
		send_image(4, 3, BPP_24, 8'd0, 20, -1);
		send_image(4, 3, BPP_24, 8'd0, 60, -1);
		send_image(2, 1, BPP_24, 8'd0, -1, -1);
		calm <= 1'b0;

		// Origin at the screen corner and beyond the screen edges
		set_origin(10'd799, 10'd479);
		send_image(3, 2, BPP_24, 8'd0, -1, -1);
		set_origin(10'h3FF, 10'h3FF);
		send_image(2, 2, BPP_32, 8'd0, -1, -1);
		set_origin(10'd0, 10'd0);

		// Random files, mostly well formed
		start_bytes = image_bytes;
		for (int n = 0; image_bytes - start_bytes < RANDOM_BYTES || checked_writes < 40; n++) begin
			if (n % 4 == 3) begin
				case ($urandom_range(0, 3))
					0: begin
						x = 10'($urandom_range(0, 799));
						y = 10'($urandom_range(0, 479));
					end
					1: begin
						x = 10'($urandom_range(780, 1023));
						y = 10'($urandom_range(0, 479));
					end
					2: begin
						x = 10'($urandom_range(0, 799));
						y = 10'($urandom_range(470, 1023));
					end
					default: begin
						x = 10'($urandom);
						y = 10'($urandom);
					end
				endcase
				set_origin(x, y);
			end
			r   = $urandom_range(0, 99);
			w   = $urandom_range(1, 8);
			h   = $urandom_range(1, 6);
			bpp = $urandom_range(0, 1) ? BPP_32 : BPP_24;
			if (r < 65) begin
				send_image(w, h, bpp, 8'd0, -1, -1);
			end else if (r < 75) begin
				// abandoned part way; the next file restarts the decoder
				send_image(w, h, BPP_24, 8'd0, $urandom_range(1, HEADER_BYTES + w * h * 3), -1);
			end else if (r < 83) begin
				if ($urandom_range(0, 1))
					send_image(0, h, bpp, 8'd0, -1, -1);
				else
					send_image(w, 0, bpp, 8'd0, -1, -1);
				send_noise($urandom_range(1, 6));
			end else if (r < 91) begin
				send_image(w, h, 8'($urandom), 8'($urandom_range(0, 3)), -1, -1);
			end else begin
				send_noise($urandom_range(1, 8));
			end
		end
		calm <= 1'b0;

		quiesce();
		$display("Streamed %0d file bytes in %0d images under %0d origin settings,",
			image_bytes, images_sent, origin_settings);
		$display("with random gaps and stalls; %0d pixel writes compared.", checked_writes);
		if (mismatch_count == 0 && pending_writes == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
